// ----- src/rwp_pkg.sv -----
// ----------------------------------------------------------------------------
// rwp_pkg
// Types and constants shared by the record wrapper and packetizer.
// ----------------------------------------------------------------------------
package rwp_pkg;

    localparam logic       OP_START    = 1'b0;
    localparam logic       OP_DATA     = 1'b1;
    localparam logic [7:0] HEADER_MARK = 8'hB0;

    // header byte index
    localparam logic [1:0] HDR_MARK = 2'd0;
    localparam logic [1:0] HDR_LO   = 2'd1;
    localparam logic [1:0] HDR_HI   = 2'd2;
    localparam logic [1:0] HDR_SUM  = 2'd3;

    typedef struct packed {
        logic        op;
        logic [15:0] record_length;
        logic [7:0]  data_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       packet_end;
        logic       record_end;
        logic       error_flag;
        logic       run_last;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_HDR  = 3'b010,
        S_PAD  = 3'b100
    } t_state;

endpackage

// ----- src/rwp_in_if.sv -----
// ----------------------------------------------------------------------------
// rwp_in_if
// Valid/ready channel carrying one input word.
// ----------------------------------------------------------------------------
interface rwp_in_if;
    logic              valid;
    logic              ready;
    rwp_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/rwp_out_if.sv -----
// ----------------------------------------------------------------------------
// rwp_out_if
// Valid/ready channel carrying one output word.
// ----------------------------------------------------------------------------
interface rwp_out_if;
    logic               valid;
    logic               ready;
    rwp_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/record_wrap_and_packetize.sv -----
// ----------------------------------------------------------------------------
// record_wrap_and_packetize
// Wraps a record in a four-byte header and cuts the stream into fixed-size
// packets, padding the last packet of each record with zeros.
// ----------------------------------------------------------------------------
// output: payload or reject word out the cycle after accept, header bytes from S_HDR
// start word: accepted, then four header bytes sent through the byte unit
// payload word: one byte; last payload word followed by up to PACKET_BYTES-1 bytes of padding
// one output word per cycle while the output is not stalled, set by the single shared byte/position unit
// reset: synchronous, clears the sequencer, output valid and record state
// ----------------------------------------------------------------------------
module record_wrap_and_packetize #(
    parameter int PACKET_BYTES = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rwp_in_if.sink    i_in,
    rwp_out_if.source o_out
);

    localparam int PW = $clog2(PACKET_BYTES);

    rwp_pkg::t_state    r_state, n_state;
    logic [15:0]        r_rem, n_rem;
    logic [PW-1:0]      r_pos, n_pos;
    logic               r_open, n_open;
    logic [1:0]         r_hidx, n_hidx;
    logic [7:0]         r_sum, n_sum;
    logic               r_out_valid, n_out_valid;
    rwp_pkg::t_out_word r_out, n_out;

    logic          w_slot;
    logic          w_accept;
    logic [PW:0]   w_pos_inc;
    logic          w_pend;
    logic [PW-1:0] w_pos_next;
    logic [15:0]   w_rem_dec;
    logic [7:0]    w_hdr_byte;

    logic       e_emit;
    logic       e_err;
    logic [7:0] e_byte;
    logic       e_rend;
    logic       e_last;

    assign w_slot     = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == rwp_pkg::S_IDLE) && w_slot;
    assign w_accept   = i_in.valid && i_in.ready;

    // shared position unit
    assign w_pos_inc  = {1'b0, r_pos} + {{PW{1'b0}}, 1'b1};
    assign w_pend     = (w_pos_inc == (PW+1)'(PACKET_BYTES));
    assign w_pos_next = w_pend ? '0 : w_pos_inc[PW-1:0];
    assign w_rem_dec  = r_rem - 16'd1;

    always_comb begin
        unique case (r_hidx)
            rwp_pkg::HDR_MARK: w_hdr_byte = rwp_pkg::HEADER_MARK;
            rwp_pkg::HDR_LO:   w_hdr_byte = r_rem[7:0];
            rwp_pkg::HDR_HI:   w_hdr_byte = r_rem[15:8];
            default:           w_hdr_byte = r_sum;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_rem   = r_rem;
        n_pos   = r_pos;
        n_open  = r_open;
        n_hidx  = r_hidx;
        n_sum   = r_sum;
        e_emit  = 1'b0;
        e_err   = 1'b0;
        e_byte  = '0;
        e_rend  = 1'b0;
        e_last  = 1'b0;

        unique case (r_state)
            rwp_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (i_in.data.op == rwp_pkg::OP_START) begin
                        if (i_in.data.record_length == 16'd0 || r_open) begin
                            e_emit = 1'b1;
                            e_err  = 1'b1;
                            e_last = 1'b1;
                        end else begin
                            n_state = rwp_pkg::S_HDR;
                            n_rem   = i_in.data.record_length;
                            n_hidx  = rwp_pkg::HDR_MARK;
                            n_sum   = '0;
                            n_pos   = '0;
                            n_open  = 1'b1;
                        end
                    end else if (!r_open) begin
                        e_emit = 1'b1;
                        e_err  = 1'b1;
                        e_last = 1'b1;
                    end else begin
                        e_emit = 1'b1;
                        e_byte = i_in.data.data_byte;
                        n_rem  = w_rem_dec;
                        n_pos  = w_pos_next;
                        if (w_rem_dec != 16'd0) begin
                            e_last = 1'b1;
                        end else begin
                            e_rend = w_pend;
                            e_last = w_pend;
                            if (w_pend) begin
                                n_open = 1'b0;
                            end else begin
                                n_state = rwp_pkg::S_PAD;
                            end
                        end
                    end
                end
            end
            rwp_pkg::S_HDR: begin
                if (w_slot) begin
                    e_emit = 1'b1;
                    e_byte = w_hdr_byte;
                    n_pos  = w_pos_next;
                    n_sum  = r_sum + w_hdr_byte;
                    n_hidx = r_hidx + 2'd1;
                    if (r_hidx == rwp_pkg::HDR_SUM) begin
                        e_last  = 1'b1;
                        n_state = rwp_pkg::S_IDLE;
                    end
                end
            end
            rwp_pkg::S_PAD: begin
                if (w_slot) begin
                    e_emit = 1'b1;
                    n_pos  = w_pos_next;
                    e_rend = w_pend;
                    e_last = w_pend;
                    if (w_pend) begin
                        n_open  = 1'b0;
                        n_state = rwp_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = rwp_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (e_emit) begin
            n_out_valid      = 1'b1;
            n_out.out_byte   = e_err ? 8'd0 : e_byte;
            n_out.packet_end = e_err ? 1'b0 : w_pend;
            n_out.record_end = e_err ? 1'b0 : e_rend;
            n_out.error_flag = e_err;
            n_out.run_last   = e_last;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rwp_pkg::S_IDLE;
            r_rem       <= '0;
            r_pos       <= '0;
            r_open      <= 1'b0;
            r_hidx      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rem       <= n_rem;
            r_pos       <= n_pos;
            r_open      <= n_open;
            r_hidx      <= n_hidx;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

`ifndef ASSERT_OFF
    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.error_flag) |->
            (r_out.run_last && r_out.out_byte == 8'd0 && !r_out.packet_end))
        else $error("error word malformed");

    a_rend_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.record_end) |-> r_out.packet_end)
        else $error("record end off a packet boundary");

    a_pad_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rwp_pkg::S_PAD || r_state == rwp_pkg::S_HDR) |-> r_open)
        else $error("header or padding with no open record");

    a_start_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.data.op == rwp_pkg::OP_START && !r_open &&
         i_in.data.record_length != 16'd0) |=>
            (r_state == rwp_pkg::S_HDR && r_hidx == rwp_pkg::HDR_MARK))
        else $error("valid start did not enter header");
`endif

endmodule
